@@ hw/rtl/pmdbd_pkg.sv @@
// ----------------------------------------------------------------------------
// pmdbd_pkg
// Shared types and constants for the protected-mode bus decoder with
// dynamic address translation.
// ----------------------------------------------------------------------------
package pmdbd_pkg;

   // field widths
   localparam int ACTION_W   = 2;
   localparam int ADDR_W     = 16;
   localparam int DATA_W     = 8;
   localparam int TARGET_W   = 3;
   localparam int LOC_W      = 21;
   localparam int PAGE_W     = 13;
   localparam int TBL_DEPTH  = 16;
   localparam int TBL_IDX_W  = $clog2(TBL_DEPTH);

   // bus actions
   typedef enum logic [ACTION_W-1:0] {
      ACT_READ  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_END   = 2'd2,
      ACT_NOP   = 2'd3
   } action_type;

   // routing targets
   typedef enum logic [TARGET_W-1:0] {
      TGT_NONE     = 3'd0,
      TGT_MAIN     = 3'd1,
      TGT_STORE    = 3'd2,
      TGT_SERIAL   = 3'd3,
      TGT_DISK     = 3'd4,
      TGT_PRINTER  = 3'd5,
      TGT_INTERNAL = 3'd6,
      TGT_SPARE    = 3'd7
   } target_type;

   // what the table read data is used for in the second stage
   typedef enum logic [1:0] {
      USE_NONE  = 2'd0,
      USE_XLATE = 2'd1,
      USE_TABLE = 2'd2,
      USE_SPARE = 2'd3
   } tbl_use_type;

   // protected window map
   localparam logic [ADDR_W-1:0] ADDR_PROT_BASE   = 16'hE000;
   localparam logic [ADDR_W-1:0] ADDR_SERIAL      = 16'hE004;
   localparam logic [ADDR_W-1:0] ADDR_SERIAL_END  = 16'hE005;
   localparam logic [ADDR_W-1:0] ADDR_DISK        = 16'hE010;
   localparam logic [ADDR_W-1:0] ADDR_DISK_END    = 16'hE017;
   localparam logic [ADDR_W-1:0] ADDR_PRINTER     = 16'hE01C;
   localparam logic [ADDR_W-1:0] ADDR_PRINTER_END = 16'hE01F;
   localparam logic [ADDR_W-1:0] ADDR_SWITCH      = 16'hE040;
   localparam logic [ADDR_W-1:0] ADDR_TABLE       = 16'hE050;
   localparam logic [ADDR_W-1:0] ADDR_TABLE_END   = 16'hE05F;
   localparam logic [ADDR_W-1:0] ADDR_MAP0        = 16'hE060;
   localparam logic [ADDR_W-1:0] ADDR_MAP1        = 16'hE070;
   localparam logic [ADDR_W-1:0] ADDR_DROP        = 16'hF000;

   // first stage contents
   typedef struct packed {
      target_type             target;
      logic [LOC_W-1:0]       location;
      logic                   is_write;
      logic [DATA_W-1:0]      data;
      logic                   prot;
      tbl_use_type            tbl_use;
   } stage_type;

endpackage

@@ hw/rtl/pmdbd_req_if.sv @@
// ----------------------------------------------------------------------------
// pmdbd_req_if
// Request channel: one bus action with its address and write byte.
// ----------------------------------------------------------------------------
interface pmdbd_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [15:0] address;
   logic [7:0]  write_data;

   modport source (output valid, output action, output address, output write_data,
                   input ready);
   modport sink   (input valid, input action, input address, input write_data,
                   output ready);
endinterface

@@ hw/rtl/pmdbd_rsp_if.sv @@
// ----------------------------------------------------------------------------
// pmdbd_rsp_if
// Response channel: routed access and the protected flag after it.
// ----------------------------------------------------------------------------
interface pmdbd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  target;
   logic [20:0] location;
   logic        is_write;
   logic [7:0]  data;
   logic        protected_mode;

   modport source (output valid, output target, output location, output is_write,
                   output data, output protected_mode, input ready);
   modport sink   (input valid, input target, input location, input is_write,
                   input data, input protected_mode, output ready);
endinterface

@@ hw/rtl/protected_mode_dat_bus_decoder_core.sv @@
// ----------------------------------------------------------------------------
// protected_mode_dat_bus_decoder_core
// Decodes bus actions of an 8-bit cpu: protected window routing, inverted
// 16-entry address translation table, map select and delayed protection exit.
// ----------------------------------------------------------------------------
//
//   channel   | dir | beat contents
//   ----------+-----+--------------------------------------------------
//   req_bus   | in  | action, address, write_data
//   rsp_bus   | out | target, location, is_write, data, protected_mode
//
// One beat per cycle while the response is taken; a beat's response is built
// by a table read in the first stage and a result register in the second.
// The translation table is a one-port-write, one-port-read memory; a write is
// seen by the very next beat, so no forwarding is needed.
// Synchronous reset sets the protected flag and clears the other control state
// and the table valid bits; an unwritten entry reads zero, needing no clearing pass.
// A stalled response holds; one more beat is taken into the first stage.
// ----------------------------------------------------------------------------
module protected_mode_dat_bus_decoder_core (
   input logic         clock,
   input logic         reset,
   pmdbd_req_if.sink   req_bus,
   pmdbd_rsp_if.source rsp_bus
);
   import pmdbd_pkg::*;

   // control state
   logic prot_ff, prot_in;
   logic leave_req_ff, leave_req_in;
   logic leave_arm_ff, leave_arm_in;
   logic map_sel_ff, map_sel_in;

   // pipeline
   logic      s1_vld_ff, s1_vld_in;
   stage_type s1_ff, s1_in;
   logic      out_vld_ff, out_vld_in;
   stage_type out_ff, out_in;
   logic      accept, out_load;

   // table memory
   logic [DATA_W-1:0]    tbl_mem [TBL_DEPTH];
   logic [TBL_DEPTH-1:0] tbl_vld_ff;
   logic [DATA_W-1:0]    tbl_rdata_ff;
   logic                 tbl_rvld_ff;
   logic                 tbl_we, tbl_re;
   logic [TBL_IDX_W-1:0] tbl_waddr, tbl_raddr;
   logic [DATA_W-1:0]    tbl_entry;

   // decode helpers
   action_type        act;
   logic [ADDR_W-1:0] addr;
   logic              wr;

   // handshake
   assign out_load      = s1_vld_ff && (!out_vld_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_vld_ff || out_load;
   assign accept        = req_bus.valid && req_bus.ready;

   assign act  = action_type'(req_bus.action);
   assign addr = req_bus.address;
   assign wr   = (act == ACT_WRITE);

   // decode and state update for the incoming beat
   always_comb begin
      s1_in        = '0;
      s1_in.target = TGT_NONE;
      s1_in.tbl_use = USE_NONE;
      prot_in      = prot_ff;
      leave_req_in = leave_req_ff;
      leave_arm_in = leave_arm_ff;
      map_sel_in   = map_sel_ff;
      tbl_we       = 1'b0;
      tbl_re       = 1'b0;
      tbl_waddr    = addr[TBL_IDX_W-1:0];
      tbl_raddr    = addr[TBL_IDX_W-1:0];

      case (act)
         ACT_END: begin
            if (leave_arm_ff) begin
               prot_in      = 1'b0;
               leave_req_in = 1'b0;
            end
            leave_arm_in = leave_arm_ff ? 1'b0 : leave_req_ff;
         end
         ACT_READ, ACT_WRITE: begin
            if (prot_ff && addr >= ADDR_PROT_BASE) begin
               if (addr inside {[ADDR_SERIAL:ADDR_SERIAL_END]}) begin
                  s1_in.target   = TGT_SERIAL;
                  s1_in.location = LOC_W'(addr - ADDR_SERIAL);
               end else if (addr inside {[ADDR_DISK:ADDR_DISK_END]}) begin
                  s1_in.target   = TGT_DISK;
                  s1_in.location = LOC_W'(addr - ADDR_DISK);
               end else if (addr inside {[ADDR_PRINTER:ADDR_PRINTER_END]}) begin
                  s1_in.target   = TGT_PRINTER;
                  s1_in.location = LOC_W'(addr - ADDR_PRINTER);
               end else if (addr == ADDR_SWITCH) begin
                  s1_in.target   = TGT_INTERNAL;
                  s1_in.location = LOC_W'(addr);
                  if (wr) leave_req_in = 1'b1;
               end else if (addr inside {[ADDR_TABLE:ADDR_TABLE_END]}) begin
                  s1_in.target   = TGT_INTERNAL;
                  s1_in.location = LOC_W'(addr);
                  if (wr) begin
                     tbl_we = 1'b1;
                  end else begin
                     tbl_re        = 1'b1;
                     s1_in.tbl_use = USE_TABLE;
                  end
               end else if (addr inside {ADDR_MAP0, ADDR_MAP1}) begin
                  s1_in.target   = TGT_INTERNAL;
                  s1_in.location = LOC_W'(addr);
                  if (wr) map_sel_in = (addr == ADDR_MAP1);
               end else if (wr && addr >= ADDR_DROP) begin
                  s1_in.target = TGT_NONE;
               end else begin
                  s1_in.target   = TGT_STORE;
                  s1_in.location = LOC_W'(addr);
               end
            end else begin
               // translated access, top bits filled from the table next stage
               s1_in.target   = TGT_MAIN;
               s1_in.location = LOC_W'(addr[PAGE_W-1:0]);
               s1_in.tbl_use  = USE_XLATE;
               tbl_re         = 1'b1;
               tbl_raddr      = {map_sel_ff, addr[ADDR_W-1:PAGE_W]};
            end
            if (wr && s1_in.target != TGT_NONE) begin
               s1_in.is_write = 1'b1;
               s1_in.data     = req_bus.write_data;
            end
         end
         default: begin
         end
      endcase
      s1_in.prot = prot_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prot_ff      <= 1'b1;
         leave_req_ff <= 1'b0;
         leave_arm_ff <= 1'b0;
         map_sel_ff   <= 1'b0;
         tbl_vld_ff   <= '0;
      end else if (accept) begin
         prot_ff      <= prot_in;
         leave_req_ff <= leave_req_in;
         leave_arm_ff <= leave_arm_in;
         map_sel_ff   <= map_sel_in;
         if (tbl_we) tbl_vld_ff[tbl_waddr] <= 1'b1;
      end
   end

   // table memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (accept && tbl_we) tbl_mem[tbl_waddr] <= req_bus.write_data;
      if (accept && tbl_re) begin
         tbl_rdata_ff <= tbl_mem[tbl_raddr];
         tbl_rvld_ff  <= tbl_vld_ff[tbl_raddr];
      end
   end

   assign tbl_entry = tbl_rvld_ff ? tbl_rdata_ff : '0;

   // second stage: merge table data into the result
   always_comb begin
      out_in = s1_ff;
      case (s1_ff.tbl_use)
         USE_XLATE: out_in.location = {~tbl_entry, s1_ff.location[PAGE_W-1:0]};
         USE_TABLE: out_in.data     = tbl_entry;
         default:   out_in          = s1_ff;
      endcase
   end

   // valid flags
   always_comb begin
      s1_vld_in  = accept ? 1'b1 : (out_load ? 1'b0 : s1_vld_ff);
      out_vld_in = out_load ? 1'b1 : ((out_vld_ff && rsp_bus.ready) ? 1'b0 : out_vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept)   s1_ff  <= s1_in;
      if (out_load) out_ff <= out_in;
   end

   // response port
   assign rsp_bus.valid          = out_vld_ff;
   assign rsp_bus.target         = out_ff.target;
   assign rsp_bus.location       = out_ff.location;
   assign rsp_bus.is_write       = out_ff.is_write;
   assign rsp_bus.data           = out_ff.data;
   assign rsp_bus.protected_mode = out_ff.prot;

   // protection never comes back without reset
   a_prot_sticky: assert property (@(posedge clock) disable iff (reset)
      !prot_ff |=> !prot_ff)
      else $error("protected flag set again");

   // the exit latch arms only from a pending request
   a_arm_from_req: assert property (@(posedge clock) disable iff (reset)
      $rose(leave_arm_ff) |-> $past(leave_req_ff))
      else $error("leave latch armed without request");

   // a first-stage beat waits until it moves on
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && !out_load |=> s1_vld_ff && $stable(s1_ff))
      else $error("first stage lost a beat");

   // an unrouted response carries nothing
   a_none_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && out_ff.target == TGT_NONE |->
         !rsp_bus.is_write && rsp_bus.data == '0 && rsp_bus.location == '0)
      else $error("unrouted response with payload");

endmodule
